FILE: sv/rmq_pkg.sv
// Shared types, widths and codes for the rotation-matrix-to-quaternion core.
package rmq_pkg;

    localparam int DW        = 16;        // entry and component width
    localparam int FB        = 14;        // fraction bits
    localparam int MW        = 17;        // magnitude of an off-diagonal sum/difference
    localparam int NW        = 32;        // radicand and dividend width
    localparam int RW        = 16;        // square root width
    localparam int REMS_W    = 18;        // square root remainder width
    localparam int REMD_W    = 17;        // divider remainder width (divisor width)
    localparam int SQ_STEPS  = NW / 2;    // one result bit per root cell
    localparam int DIV_STEPS = NW;        // one quotient bit per divider cell
    localparam int LANES     = 4;
    localparam int LAT       = 1 + SQ_STEPS + 1 + DIV_STEPS + 1;

    // branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_M11   = 2'd1;
    localparam logic [1:0] BR_M22   = 2'd2;
    localparam logic [1:0] BR_M33   = 2'd3;

    // component lanes
    localparam logic [1:0] L_X = 2'd0;
    localparam logic [1:0] L_Y = 2'd1;
    localparam logic [1:0] L_Z = 2'd2;
    localparam logic [1:0] L_W = 2'd3;

    // side data that travels along the root chain
    typedef struct packed {
        logic                       vld;
        logic [1:0]                 br;
        logic                       degen;
        logic [LANES-1:0]           neg;
        logic [LANES-1:0][MW-1:0]   mag;
    } sq_side_t;

    // side data that travels along the divider chain
    typedef struct packed {
        logic             vld;
        logic [1:0]       br;
        logic             degen;
        logic [LANES-1:0] neg;
        logic [RW-1:0]    mainc;
    } dv_side_t;

    // lane that carries r/2 for a branch
    function automatic logic [1:0] main_lane(input logic [1:0] br);
        logic [1:0] l;
        case (br)
            BR_TRACE: l = L_W;
            BR_M11:   l = L_X;
            BR_M22:   l = L_Y;
            BR_M33:   l = L_Z;
            default:  l = L_W;
        endcase
        return l;
    endfunction

endpackage

FILE: sv/rmq_sqrt_cell.sv
// One restoring square-root cell: settles one root bit per item per cycle.
module rmq_sqrt_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rmq_pkg::sq_side_t         side_i,
    input  logic [rmq_pkg::REMS_W-1:0] rem_i,
    input  logic [rmq_pkg::RW-1:0]    root_i,
    input  logic [rmq_pkg::NW-1:0]    rad_i,
    output rmq_pkg::sq_side_t         side_o,
    output logic [rmq_pkg::REMS_W-1:0] rem_o,
    output logic [rmq_pkg::RW-1:0]    root_o,
    output logic [rmq_pkg::NW-1:0]    rad_o
);
    import rmq_pkg::*;

    logic [REMS_W+1:0] cur;
    logic [REMS_W+1:0] trial;
    logic [REMS_W+1:0] diff;
    logic              take;
    logic [REMS_W-1:0] rem_next;
    logic [RW-1:0]     root_next;
    logic [NW-1:0]     rad_next;
    sq_side_t          side_reg;
    logic [REMS_W-1:0] rem_reg;
    logic [RW-1:0]     root_reg;
    logic [NW-1:0]     rad_reg;

    // trial subtract of (4*root + 1)
    always_comb
    begin
        cur       = {rem_i, rad_i[NW-1 -: 2]};
        trial     = {2'b00, root_i, 2'b01};
        diff      = cur - trial;
        take      = (cur >= trial);
        rem_next  = take ? diff[REMS_W-1:0] : cur[REMS_W-1:0];
        root_next = {root_i[RW-2:0], take};
        rad_next  = {rad_i[NW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        root_reg       <= root_next;
        rad_reg        <= rad_next;
    end

    assign side_o = side_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign rad_o  = rad_reg;

endmodule

FILE: sv/rmq_div_cell.sv
// One restoring divider cell: one quotient bit for each of the four lanes.
module rmq_div_cell
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  rmq_pkg::dv_side_t                              side_i,
    input  logic [rmq_pkg::REMD_W-1:0]                     dvs_i,
    input  logic [rmq_pkg::LANES-1:0][rmq_pkg::REMD_W-1:0] rem_i,
    input  logic [rmq_pkg::LANES-1:0][rmq_pkg::NW-1:0]     num_i,
    input  logic [rmq_pkg::LANES-1:0][rmq_pkg::NW-1:0]     quo_i,
    output rmq_pkg::dv_side_t                              side_o,
    output logic [rmq_pkg::REMD_W-1:0]                     dvs_o,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::REMD_W-1:0] rem_o,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::NW-1:0]     num_o,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::NW-1:0]     quo_o
);
    import rmq_pkg::*;

    logic [LANES-1:0][REMD_W:0]   sh;
    logic [LANES-1:0]             take;
    logic [LANES-1:0][REMD_W-1:0] rem_next;
    dv_side_t                     side_reg;
    logic [REMD_W-1:0]            dvs_reg;
    logic [LANES-1:0][REMD_W-1:0] rem_reg;
    logic [LANES-1:0][NW-1:0]     num_reg;
    logic [LANES-1:0][NW-1:0]     quo_reg;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sh[l]       = {rem_i[l], num_i[l][NW-1]};
            take[l]     = (sh[l] >= {1'b0, dvs_i});
            rem_next[l] = take[l] ? REMD_W'(sh[l] - {1'b0, dvs_i}) : sh[l][REMD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg        <= dvs_i;
        for (int l = 0; l < LANES; l++)
        begin
            rem_reg[l] <= rem_next[l];
            num_reg[l] <= {num_i[l][NW-2:0], 1'b0};
            quo_reg[l] <= {quo_i[l][NW-2:0], take[l]};
        end
    end

    assign side_o = side_reg;
    assign dvs_o  = dvs_reg;
    assign rem_o  = rem_reg;
    assign num_o  = num_reg;
    assign quo_o  = quo_reg;

endmodule

FILE: sv/rotation_matrix_to_quaternion_core.sv
// Top level: rotation matrix to unit quaternion, pipelined cell chains.
//
// Usage:
//   Drive the nine matrix entries (signed Q2.14) with start high for one
//   cycle; the item transfers at that edge. busy is always low, so a new
//   matrix may be presented every cycle.
//   The result (qx, qy, qz, qw, branch, degenerate) appears on its ports
//   with done high for exactly one cycle, and transfers at the edge that
//   ends that cycle.
//   Throughput is one item per cycle; latency is set by the chain of 16
//   square-root cells (one root bit each) followed by the chain of 32
//   divider cells (one quotient bit each), plus an input stage, a
//   dividend stage and an output register.
//   Results arrive in the order items were taken. The receiver cannot
//   stall; done marks the only cycle a result is shown.
//   Reset (rst_n low, asynchronous) clears all valid bits in the chains,
//   so no done is produced for items in flight at reset.
//   A non-positive radicand gives zero components with degenerate set.
module rotation_matrix_to_quaternion_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [rmq_pkg::DW-1:0] m11,
    input  logic signed [rmq_pkg::DW-1:0] m12,
    input  logic signed [rmq_pkg::DW-1:0] m13,
    input  logic signed [rmq_pkg::DW-1:0] m21,
    input  logic signed [rmq_pkg::DW-1:0] m22,
    input  logic signed [rmq_pkg::DW-1:0] m23,
    input  logic signed [rmq_pkg::DW-1:0] m31,
    input  logic signed [rmq_pkg::DW-1:0] m32,
    input  logic signed [rmq_pkg::DW-1:0] m33,
    output logic                        done,
    output logic signed [rmq_pkg::DW-1:0] qx,
    output logic signed [rmq_pkg::DW-1:0] qy,
    output logic signed [rmq_pkg::DW-1:0] qz,
    output logic signed [rmq_pkg::DW-1:0] qw,
    output logic [1:0]                  branch,
    output logic                        degenerate
);
    import rmq_pkg::*;

    // input stage
    logic signed [DW+1:0]         t;
    logic signed [DW+2:0]         a;
    logic [1:0]                   br;
    logic signed [DW+1:0]         d [LANES];
    sq_side_t                     s0_next;
    logic [NW-1:0]                rad_next;
    sq_side_t                     s0_reg;
    logic [NW-1:0]                rad_reg;

    // chains
    sq_side_t                     sq_side [SQ_STEPS+1];
    logic [REMS_W-1:0]            sq_rem  [SQ_STEPS+1];
    logic [RW-1:0]                sq_root [SQ_STEPS+1];
    logic [NW-1:0]                sq_rad  [SQ_STEPS+1];
    dv_side_t                     dv_side [DIV_STEPS+1];
    logic [REMD_W-1:0]            dv_dvs  [DIV_STEPS+1];
    logic [LANES-1:0][REMD_W-1:0] dv_rem  [DIV_STEPS+1];
    logic [LANES-1:0][NW-1:0]     dv_num  [DIV_STEPS+1];
    logic [LANES-1:0][NW-1:0]     dv_quo  [DIV_STEPS+1];

    // dividend stage
    logic [RW:0]                  r_inc;
    dv_side_t                     nm_next;
    dv_side_t                     nm_reg;
    logic [REMD_W-1:0]            dvs_reg;
    logic [LANES-1:0][NW-1:0]     num_next;
    logic [LANES-1:0][NW-1:0]     num_reg;

    // output stage
    dv_side_t                     fin;
    logic [1:0]                   ml;
    logic [LANES-1:0][DW-1:0]     comp;
    logic [NW-1:0]                qv;
    logic                         done_reg;
    logic [LANES-1:0][DW-1:0]     q_reg;
    logic [1:0]                   br_reg;
    logic                         degen_reg;

    assign busy = 1'b0;

    // branch choice, radicand and off-diagonal terms
    always_comb
    begin
        t = (DW+2)'(m11) + (DW+2)'(m22) + (DW+2)'(m33);
        if (t > 0)
        begin
            br = BR_TRACE;
            a  = (DW+3)'(t) + (DW+3)'(1 << FB);
        end
        else if (m11 > m22 && m11 > m33)
        begin
            br = BR_M11;
            a  = (DW+3)'(1 << FB) + (DW+3)'(m11) - (DW+3)'(m22) - (DW+3)'(m33);
        end
        else if (m22 > m33)
        begin
            br = BR_M22;
            a  = (DW+3)'(1 << FB) + (DW+3)'(m22) - (DW+3)'(m11) - (DW+3)'(m33);
        end
        else
        begin
            br = BR_M33;
            a  = (DW+3)'(1 << FB) + (DW+3)'(m33) - (DW+3)'(m11) - (DW+3)'(m22);
        end

        d[L_X] = '0;
        d[L_Y] = '0;
        d[L_Z] = '0;
        d[L_W] = '0;
        case (br)
            BR_TRACE:
            begin
                d[L_X] = (DW+2)'(m32) - (DW+2)'(m23);
                d[L_Y] = (DW+2)'(m13) - (DW+2)'(m31);
                d[L_Z] = (DW+2)'(m21) - (DW+2)'(m12);
            end
            BR_M11:
            begin
                d[L_W] = (DW+2)'(m32) - (DW+2)'(m23);
                d[L_Y] = (DW+2)'(m12) + (DW+2)'(m21);
                d[L_Z] = (DW+2)'(m13) + (DW+2)'(m31);
            end
            BR_M22:
            begin
                d[L_W] = (DW+2)'(m13) - (DW+2)'(m31);
                d[L_X] = (DW+2)'(m12) + (DW+2)'(m21);
                d[L_Z] = (DW+2)'(m23) + (DW+2)'(m32);
            end
            default:
            begin
                d[L_W] = (DW+2)'(m21) - (DW+2)'(m12);
                d[L_X] = (DW+2)'(m13) + (DW+2)'(m31);
                d[L_Y] = (DW+2)'(m23) + (DW+2)'(m32);
            end
        endcase

        s0_next.vld   = start;
        s0_next.br    = br;
        s0_next.degen = (a <= 0);
        for (int l = 0; l < LANES; l++)
        begin
            s0_next.neg[l] = d[l][DW+1];
            s0_next.mag[l] = d[l][DW+1] ? MW'(-d[l]) : MW'(d[l]);
        end
        rad_next = s0_next.degen ? '0 : {1'b0, a[MW-1:0], {FB{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
    end

    // square root chain
    assign sq_side[0] = s0_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = rad_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        rmq_sqrt_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .side_i (sq_side[k]),
            .rem_i  (sq_rem[k]),
            .root_i (sq_root[k]),
            .rad_i  (sq_rad[k]),
            .side_o (sq_side[k+1]),
            .rem_o  (sq_rem[k+1]),
            .root_o (sq_root[k+1]),
            .rad_o  (sq_rad[k+1])
        );
    end

    // dividend |d| * ONE + r, divisor 2r, main component (r + 1) / 2
    always_comb
    begin
        r_inc         = {1'b0, sq_root[SQ_STEPS]} + (RW+1)'(1);
        nm_next.vld   = sq_side[SQ_STEPS].vld;
        nm_next.br    = sq_side[SQ_STEPS].br;
        nm_next.degen = sq_side[SQ_STEPS].degen;
        nm_next.neg   = sq_side[SQ_STEPS].neg;
        nm_next.mainc = r_inc[RW:1];
        for (int l = 0; l < LANES; l++)
        begin
            num_next[l] = {1'b0, sq_side[SQ_STEPS].mag[l], {FB{1'b0}}}
                          + NW'(sq_root[SQ_STEPS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_reg <= '0;
        end
        else
        begin
            nm_reg <= nm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg      <= {sq_root[SQ_STEPS], 1'b0};
        num_reg      <= num_next;
    end

    // divider chain
    assign dv_side[0] = nm_reg;
    assign dv_dvs[0]  = dvs_reg;
    assign dv_rem[0]  = '0;
    assign dv_num[0]  = num_reg;
    assign dv_quo[0]  = '0;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_dv
        rmq_div_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .side_i (dv_side[k]),
            .dvs_i  (dv_dvs[k]),
            .rem_i  (dv_rem[k]),
            .num_i  (dv_num[k]),
            .quo_i  (dv_quo[k]),
            .side_o (dv_side[k+1]),
            .dvs_o  (dv_dvs[k+1]),
            .rem_o  (dv_rem[k+1]),
            .num_o  (dv_num[k+1]),
            .quo_o  (dv_quo[k+1])
        );
    end

    // sign, saturation and component select
    always_comb
    begin
        fin = dv_side[DIV_STEPS];
        ml  = main_lane(fin.br);
        qv  = '0;
        for (int l = 0; l < LANES; l++)
        begin
            qv = dv_quo[DIV_STEPS][l];
            if (fin.degen)
            begin
                comp[l] = '0;
            end
            else if (2'(l) == ml)
            begin
                comp[l] = fin.mainc[DW-1:0];
            end
            else if (fin.neg[l])
            begin
                comp[l] = (qv >= NW'(1 << (DW-1))) ? {1'b1, {(DW-1){1'b0}}}
                                                    : DW'(-qv);
            end
            else
            begin
                comp[l] = (qv > NW'((1 << (DW-1)) - 1)) ? {1'b0, {(DW-1){1'b1}}}
                                                        : qv[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= comp;
        br_reg    <= fin.br;
        degen_reg <= fin.degen;
    end

    assign done       = done_reg;
    assign qx         = q_reg[L_X];
    assign qy         = q_reg[L_Y];
    assign qz         = q_reg[L_Z];
    assign qw         = q_reg[L_W];
    assign branch     = br_reg;
    assign degenerate = degen_reg;

endmodule

FILE: sv/rmq_checker.sv
// Port-level checks for the rotation-matrix-to-quaternion core, with bind.
module rmq_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          done,
    input logic signed [rmq_pkg::DW-1:0] qx,
    input logic signed [rmq_pkg::DW-1:0] qy,
    input logic signed [rmq_pkg::DW-1:0] qz,
    input logic signed [rmq_pkg::DW-1:0] qw,
    input logic [1:0]                    branch,
    input logic                          degenerate
);
    import rmq_pkg::*;

    // the core never refuses a transfer
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // degenerate results carry zero components
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
        else $error("degenerate result not zero");

    // trace branch always has a positive radicand
    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && branch == BR_TRACE |-> !degenerate && qw > 0)
        else $error("trace branch result bad");

    // the main component of a diagonal branch is positive
    a_main_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |->
            (branch == BR_M11 && qx > 0) || (branch == BR_M22 && qy > 0) ||
            (branch == BR_M33 && qz > 0) || (branch == BR_TRACE))
        else $error("main component not positive");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .done       (done),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .qw         (qw),
    .branch     (branch),
    .degenerate (degenerate)
);

FILE: tb/sv/rotation_matrix_to_quaternion_core_tb.sv
// Testbench for the rotation-matrix-to-quaternion core: self-predicting, per-field checks.
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_core_tb;
    import rmq_pkg::*;

    typedef struct {
        logic signed [DW-1:0] qx, qy, qz, qw;
        logic [1:0] br;
        logic degen;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [DW-1:0] m11 = '0, m12 = '0, m13 = '0, m21 = '0, m22 = '0;
    logic signed [DW-1:0] m23 = '0, m31 = '0, m32 = '0, m33 = '0;
    logic done;
    logic signed [DW-1:0] qx, qy, qz, qw;
    logic [1:0] branch;
    logic degenerate;

    quat_t pending_quats[$];
    int n_mismatch = 0;
    int n_checked = 0;
    int n_sent = 0;
    int n_degen = 0;
    bit idle_on = 1'b1;

    rotation_matrix_to_quaternion_core i_dut (.*);

    always #4 clk = ~clk;

    // floor square root, bit by bit
    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // d/(2r), nearest, ties away from zero
    function automatic longint round_div(input longint d, input longint r);
        longint mag, q;
        mag = (d < 0) ? -d : d;
        q = ((mag << FB) + r) / (2 * r);
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic signed [DW-1:0] sat16(input longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[DW-1:0];
    endfunction

    function automatic quat_t predict_quat(input longint a11, a12, a13, a21, a22, a23,
                                           a31, a32, a33);
        quat_t e;
        longint t, rad, dx, dy, dz, dw, r, mc;
        longint cx, cy, cz, cw;
        logic [1:0] br;
        dx = 0; dy = 0; dz = 0; dw = 0;
        cx = 0; cy = 0; cz = 0; cw = 0;
        t = a11 + a22 + a33;
        if (t > 0)
        begin
            br = BR_TRACE; rad = t + (1 << FB);
            dx = a32 - a23; dy = a13 - a31; dz = a21 - a12;
        end
        else if (a11 > a22 && a11 > a33)
        begin
            br = BR_M11; rad = (1 << FB) + a11 - a22 - a33;
            dw = a32 - a23; dy = a12 + a21; dz = a13 + a31;
        end
        else if (a22 > a33)
        begin
            br = BR_M22; rad = (1 << FB) + a22 - a11 - a33;
            dw = a13 - a31; dx = a12 + a21; dz = a23 + a32;
        end
        else
        begin
            br = BR_M33; rad = (1 << FB) + a33 - a11 - a22;
            dw = a21 - a12; dx = a13 + a31; dy = a23 + a32;
        end
        e.degen = (rad <= 0);
        if (!e.degen)
        begin
            r = isqrt(rad << FB);
            mc = (r + 1) >> 1;
            cx = (br == BR_M11) ? mc : round_div(dx, r);
            cy = (br == BR_M22) ? mc : round_div(dy, r);
            cz = (br == BR_M33) ? mc : round_div(dz, r);
            cw = (br == BR_TRACE) ? mc : round_div(dw, r);
        end
        e.qx = sat16(cx); e.qy = sat16(cy); e.qz = sat16(cz); e.qw = sat16(cw);
        e.br = br;
        return e;
    endfunction

    // send one matrix; start held across back-to-back transfers
    task automatic send_matrix(input logic signed [DW-1:0] v[9]);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        m11 <= v[0]; m12 <= v[1]; m13 <= v[2];
        m21 <= v[3]; m22 <= v[4]; m23 <= v[5];
        m31 <= v[6]; m32 <= v[7]; m33 <= v[8];
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_quats.push_back(predict_quat(v[0], v[1], v[2], v[3], v[4], v[5],
                                             v[6], v[7], v[8]));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic release_start();
        start <= 1'b0;
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        quat_t e;
        if (rst_n && done)
        begin
            if (pending_quats.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result transfer");
            end
            else
            begin
                e = pending_quats.pop_front();
                n_checked++;
                if (e.degen) n_degen++;
                if (qx !== e.qx || qy !== e.qy || qz !== e.qz || qw !== e.qw ||
                    branch !== e.br || degenerate !== e.degen)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"exp q=%0d %0d %0d %0d br=%0d dg=%0d ",
                                  "got %0d %0d %0d %0d br=%0d dg=%0d"},
                                 e.qx, e.qy, e.qz, e.qw, e.br, e.degen,
                                 qx, qy, qz, qw, branch, degenerate);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_quats.size() != 0) @(negedge clk);
    endtask

    function automatic logic signed [DW-1:0] rnd16();
        return DW'($urandom_range(0, 16'hffff));
    endfunction

    // matrix from a random unit quaternion, with small noise
    task automatic make_rotation(output logic signed [DW-1:0] v[9]);
        real a, b, c, d, n;
        real rm[9];
        a = $urandom_range(0, 20000) / 10000.0 - 1.0;
        b = $urandom_range(0, 20000) / 10000.0 - 1.0;
        c = $urandom_range(0, 20000) / 10000.0 - 1.0;
        d = $urandom_range(0, 20000) / 10000.0 - 1.0;
        n = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
        a /= n; b /= n; c /= n; d /= n;
        rm[0] = 1 - 2*(c*c + d*d); rm[1] = 2*(b*c - d*a); rm[2] = 2*(b*d + c*a);
        rm[3] = 2*(b*c + d*a); rm[4] = 1 - 2*(b*b + d*d); rm[5] = 2*(c*d - b*a);
        rm[6] = 2*(b*d - c*a); rm[7] = 2*(c*d + b*a); rm[8] = 1 - 2*(b*b + c*c);
        for (int i = 0; i < 9; i++)
            v[i] = DW'($rtoi(rm[i] * 16384.0) + $signed($urandom_range(0, 4)) - 2);
    endtask

    task automatic test_directed();
        logic signed [DW-1:0] v[9];
        // identity, zero, all max, all min
        v = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(v);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(v);
        v = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(v);
        v = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(v);
        // half-turns: each diagonal branch
        v = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(v);
        v = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(v);
        v = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(v);
        // ties on the diagonal with trace not positive
        v = '{-100, 5, 6, 7, -100, 8, 9, 10, 200}; send_matrix(v);
        v = '{0, 1, 2, 3, 0, 4, 5, 6, 0}; send_matrix(v);
        // negative diagonal entries, branches of m33 and m22
        v = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}; send_matrix(v);
        v = '{-20000, 0, 0, 0, -32768, 0, 0, 0, 32767}; send_matrix(v);
        v = '{-10000, 0, 0, 0, 5000, 0, 0, 0, -32000}; send_matrix(v);
        // equal diagonal entries of -1.0, branch of m33
        v = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(v);
        // extreme off-diagonal entries at small, negative and large traces
        v = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0}; send_matrix(v);
        v = '{-32768, 32767, 32767, 32767, 0, 32767, 32767, 32767, 0}; send_matrix(v);
        v = '{16384, -32768, 32767, 32767, 16384, -32768, -32768, 32767, 16384};
        send_matrix(v);
        release_start();
    endtask

    task automatic test_random(input int count);
        logic signed [DW-1:0] v[9];
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) != 0)
                make_rotation(v);
            else
                for (int i = 0; i < 9; i++) v[i] = rnd16();
            send_matrix(v);
        end
        release_start();
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        wait_drained();
        test_random(600);
        // let the pipeline drain fully before continuing
        wait_drained();
        test_random(550);
        idle_on = 1'b0;
        test_random(200);
        wait_drained();
        repeat (LAT + 10) @(negedge clk);
        $display("sent %0d matrices, checked %0d quaternions, %0d degenerate",
                 n_sent, n_checked, n_degen);
        $display("covered all branches, extremes, ties and saturation; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0 && pending_quats.size() == 0)
            $display("rotation_matrix_to_quaternion_core: match");
        else
            $display("rotation_matrix_to_quaternion_core: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("rotation_matrix_to_quaternion_core: mismatch");
        $finish;
    end

endmodule
